[design/spp_pkg.sv]
// Shared widths, register indexes, codes and controller/datapath structs for the packet pacer.
`default_nettype none

package spp_pkg;

  // Field widths
  localparam int COUNT_W    = 32;
  localparam int DELAY_W    = 20;
  localparam int SEND_W     = 9;
  localparam int ADJ_W      = 2;
  localparam int BURST_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Delay limit and register reset values
  localparam logic [DELAY_W-1:0] DELAY_MAX    = {DELAY_W{1'b1}};
  localparam logic [DELAY_W-1:0] INTERVAL_RST = 20'd1000000;
  localparam logic [COUNT_W-1:0] TOTAL_RST    = 32'd10;

  // Defaults for the top-level parameters
  localparam int WINDOW_DEF    = 50;
  localparam int MAX_BURST_DEF = 255;

  // Shared divider geometry
  localparam int DIV_N     = 32;
  localparam int DIV_D     = 20;
  localparam int DIV_CNT_W = $clog2(DIV_N);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL    = 2'd1;

  // Adjustment codes
  localparam logic [ADJ_W-1:0] ADJ_NONE = 2'd0;
  localparam logic [ADJ_W-1:0] ADJ_DEC  = 2'd1;
  localparam logic [ADJ_W-1:0] ADJ_INC  = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic latch;     // capture the input beat
    logic eval;      // first pass over the tick
    logic cal;       // apply calibration result
    logic res_load;  // store window residue from divider
    logic out_load;  // move result into output register
    logic div_go;    // launch the divider
    logic div_late;  // divider operands: lateness / interval
  } spp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic eval_late; // tick needs a lateness divide
    logic eval_res;  // run start needs a residue divide
    logic cal_res;   // burst sent, residue must be recomputed
    logic div_done;
    logic out_free;
  } spp_sts_t;

endpackage

`default_nettype wire

[design/spp_div.sv]
// Restoring divider, one quotient bit per cycle, shared by lateness and window residue.
`default_nettype none

module spp_div
  import spp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DIV_N-1:0] dividend,
  input  logic [DIV_D-1:0] divisor,
  output logic             done,
  output logic [DIV_N-1:0] quotient,
  output logic [DIV_D-1:0] remainder
);

  logic [DIV_N-1:0]     quo_r;
  logic [DIV_D-1:0]     rem_r;
  logic [DIV_D-1:0]     dsr_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic [DIV_D:0]       partial;
  logic [DIV_D+1:0]     trial;
  logic                 fits;
  logic [DIV_D-1:0]     rem_nxt;
  logic                 last;

  // Trial subtraction for the next quotient bit
  always_comb begin
    partial = {rem_r, quo_r[DIV_N-1]};
    trial   = {1'b0, partial} - {2'b00, dsr_r};
    fits    = ~trial[DIV_D+1];
    rem_nxt = fits ? trial[DIV_D-1:0] : partial[DIV_D-1:0];
    last    = (cnt_r == DIV_CNT_W'(DIV_N - 1));
  end

  // Sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (go) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Shift registers
  always_ff @(posedge clk) begin
    if (go) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIV_N-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

[design/spp_dp.sv]
// Pacer datapath: configuration, run state, calibration arithmetic and output register.
`default_nettype none

module spp_dp
  import spp_pkg::*;
#(
  parameter int WINDOW    = WINDOW_DEF,
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  spp_cmd_t              cmd,
  output spp_sts_t              sts,
  input  logic                  in_start_req,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [SEND_W-1:0]     out_send_count,
  output logic [COUNT_W-1:0]    out_remaining,
  output logic [DELAY_W-1:0]    out_current_delay,
  output logic [ADJ_W-1:0]      out_adjusted,
  output logic                  out_busy_res
);

  localparam int RES_W  = $clog2(WINDOW);
  localparam int PROD_W = DELAY_W + $clog2(WINDOW + 1);
  localparam logic [RES_W-1:0]   RES_TOP      = RES_W'(WINDOW - 1);
  localparam logic [COUNT_W-1:0] LATE_DEC_LIM = COUNT_W'(WINDOW / 4);
  localparam logic [COUNT_W-1:0] LATE_INC_LIM = COUNT_W'(WINDOW / 8);
  localparam logic [COUNT_W-1:0] BURST_CAP    = COUNT_W'(MAX_BURST);

  // Configuration
  logic [DELAY_W-1:0] interval_r;
  logic [COUNT_W-1:0] total_r;

  // Run state
  logic [COUNT_W-1:0] time_r;
  logic [COUNT_W-1:0] left_r;
  logic [DELAY_W-1:0] delay_r;
  logic [DELAY_W-1:0] wait_r;
  logic [COUNT_W-1:0] wstart_r;
  logic               wopen_r;
  logic               run_r;
  logic [RES_W-1:0]   res_r;     // (left + 1) mod WINDOW

  // Per-tick working registers
  logic               start_r;
  logic [SEND_W-1:0]  sends_r;
  logic [ADJ_W-1:0]   adj_r;
  logic [PROD_W-1:0]  ivw_r;
  logic               late_neg_r;

  // Output register
  logic               out_valid_r;
  logic [SEND_W-1:0]  out_send_r;
  logic [COUNT_W-1:0] out_left_r;
  logic [DELAY_W-1:0] out_delay_r;
  logic [ADJ_W-1:0]   out_adj_r;
  logic               out_busy_r;

  logic [DELAY_W-1:0] eff_iv;
  logic [PROD_W-1:0]  ivw_nxt;
  logic [COUNT_W-1:0] elapsed;
  logic [COUNT_W:0]   late_us;
  logic [COUNT_W:0]   late_abs;
  logic               late_neg;
  logic [DELAY_W-1:0] wait_dec;
  logic               expire;
  logic               at_bound;
  logic [RES_W-1:0]   res_dec;

  logic [DIV_N-1:0]   div_quo;
  logic [DIV_D-1:0]   div_rem;
  logic               div_done;
  logic [DIV_N-1:0]   div_dividend;
  logic [DIV_D-1:0]   div_divisor;

  logic               dec_hit;
  logic               inc_hit;
  logic               late_pos;
  logic [BURST_W-1:0] qcap;
  logic [BURST_W-1:0] burst;
  logic [COUNT_W-1:0] left_cal;
  logic [COUNT_W-1:0] left_cal_fin;
  logic [DELAY_W-1:0] delay_cal;

  // Tick evaluation terms; a zero interval counts as one
  always_comb begin
    eff_iv   = (interval_r == '0) ? DELAY_W'(1) : interval_r;
    ivw_nxt  = PROD_W'(eff_iv) * PROD_W'(WINDOW);
    elapsed  = time_r - wstart_r;
    late_us  = {1'b0, elapsed} - (COUNT_W + 1)'(ivw_r);
    late_neg = late_us[COUNT_W];
    late_abs = late_neg ? (~late_us + 1'b1) : late_us;
    wait_dec = (wait_r != '0) ? wait_r - 1'b1 : '0;
    expire   = (wait_dec == '0);
    at_bound = (res_r == '0);
    res_dec  = (res_r == '0) ? RES_TOP : res_r - 1'b1;
  end

  // Calibration outcome from the divider quotient
  always_comb begin
    dec_hit  = ~late_neg_r & (div_quo > LATE_DEC_LIM);
    inc_hit  =  late_neg_r & (div_quo > LATE_INC_LIM);
    late_pos = ~late_neg_r & (div_quo != '0);
    qcap     = (div_quo > BURST_CAP) ? BURST_CAP[BURST_W-1:0] : div_quo[BURST_W-1:0];
    if (!late_pos) begin
      burst = '0;
    end else if (left_r < COUNT_W'(qcap)) begin
      burst = left_r[BURST_W-1:0];
    end else begin
      burst = qcap;
    end
    left_cal     = left_r - COUNT_W'(burst);
    left_cal_fin = (left_cal != '0) ? left_cal - 1'b1 : '0;
    if (dec_hit) begin
      delay_cal = (delay_r > DELAY_W'(1)) ? delay_r - 1'b1 : delay_r;
    end else if (inc_hit) begin
      delay_cal = (delay_r != DELAY_MAX) ? delay_r + 1'b1 : delay_r;
    end else begin
      delay_cal = delay_r;
    end
  end

  // Divider operand selection
  always_comb begin
    if (cmd.div_late) begin
      div_dividend = late_abs[COUNT_W-1:0];
      div_divisor  = eff_iv;
    end else if (cmd.eval) begin
      div_dividend = total_r;
      div_divisor  = DIV_D'(WINDOW);
    end else begin
      div_dividend = left_cal_fin + 1'b1;
      div_divisor  = DIV_D'(WINDOW);
    end
  end

  spp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .go        (cmd.div_go),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Status to the controller
  always_comb begin
    sts.eval_late = ~start_r & run_r & expire & at_bound & wopen_r;
    sts.eval_res  = start_r & (total_r != '0);
    sts.cal_res   = (burst != '0);
    sts.div_done  = div_done;
    sts.out_free  = ~out_valid_r | out_ready;
  end

  // Configuration and run state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r  <= INTERVAL_RST;
      total_r     <= TOTAL_RST;
      time_r      <= '0;
      left_r      <= '0;
      delay_r     <= DELAY_W'(1);
      wait_r      <= '0;
      wstart_r    <= '0;
      wopen_r     <= 1'b0;
      run_r       <= 1'b0;
      res_r       <= '0;
      start_r     <= 1'b0;
      sends_r     <= '0;
      adj_r       <= ADJ_NONE;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_INTERVAL: interval_r <= cfg_data[DELAY_W-1:0];
          REG_TOTAL:    total_r    <= cfg_data;
          default:      ;
        endcase
      end

      if (cmd.latch) begin
        start_r <= in_start_req;
      end

      // First pass: start, countdown, plain send
      if (cmd.eval) begin
        adj_r   <= ADJ_NONE;
        sends_r <= '0;
        if (start_r) begin
          delay_r <= eff_iv;
          wopen_r <= 1'b0;
          if (total_r != '0) begin
            left_r  <= total_r - 1'b1;
            sends_r <= SEND_W'(1);
            wait_r  <= eff_iv;
            run_r   <= 1'b1;
          end else begin
            left_r <= '0;
            wait_r <= '0;
            run_r  <= 1'b0;
          end
        end else if (run_r) begin
          wait_r <= wait_dec;
          if (expire && !(at_bound && wopen_r)) begin
            if (at_bound) begin
              wstart_r <= time_r;
              wopen_r  <= 1'b1;
            end
            if (left_r != '0) begin
              left_r  <= left_r - 1'b1;
              sends_r <= SEND_W'(1);
              wait_r  <= delay_r;
              res_r   <= res_dec;
            end else begin
              run_r   <= 1'b0;
              wopen_r <= 1'b0;
            end
          end
        end
      end

      // Window boundary with a lateness result
      if (cmd.cal) begin
        delay_r  <= delay_cal;
        adj_r    <= dec_hit ? ADJ_DEC : (inc_hit ? ADJ_INC : ADJ_NONE);
        wstart_r <= time_r;
        wopen_r  <= 1'b1;
        if (left_cal != '0) begin
          left_r  <= left_cal - 1'b1;
          sends_r <= SEND_W'(burst) + 1'b1;
          wait_r  <= delay_cal;
          res_r   <= res_dec;
        end else begin
          left_r  <= left_cal;
          sends_r <= SEND_W'(burst);
          run_r   <= 1'b0;
          wopen_r <= 1'b0;
        end
      end

      if (cmd.res_load) begin
        res_r <= div_rem[RES_W-1:0];
      end

      // Tick closes when its result beat is registered
      if (cmd.out_load) begin
        time_r      <= time_r + 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    ivw_r <= ivw_nxt;
    if (cmd.div_go && cmd.div_late) begin
      late_neg_r <= late_neg;
    end
    if (cmd.out_load) begin
      out_send_r  <= sends_r;
      out_left_r  <= left_r;
      out_delay_r <= delay_r;
      out_adj_r   <= adj_r;
      out_busy_r  <= run_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_send_count    = out_send_r;
  assign out_remaining     = out_left_r;
  assign out_current_delay = out_delay_r;
  assign out_adjusted      = out_adj_r;
  assign out_busy_res      = out_busy_r;

endmodule

`default_nettype wire

[design/spp_ctrl.sv]
// Pacer controller: sequences one tick through evaluation, divides and result hand-off.
`default_nettype none

module spp_ctrl
  import spp_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  spp_sts_t sts,
  output spp_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIVL = 3'd2;
  localparam logic [2:0] S_CAL  = 3'd3;
  localparam logic [2:0] S_DIVR = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.eval_late) begin
          cmd.div_go   = 1'b1;
          cmd.div_late = 1'b1;
          state_nxt    = S_DIVL;
        end else if (sts.eval_res) begin
          cmd.div_go = 1'b1;
          state_nxt  = S_DIVR;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIVL: begin
        if (sts.div_done) begin
          state_nxt = S_CAL;
        end
      end
      S_CAL: begin
        cmd.cal = 1'b1;
        if (sts.cal_res) begin
          cmd.div_go = 1'b1;
          state_nxt  = S_DIVR;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_DIVR: begin
        if (sts.div_done) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

`default_nettype wire

[design/self_calibrating_packet_pacer_unit.sv]
// Top level of the self-calibrating packet pacer: controller, datapath and config port.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------------
//   in_     | in        | in_valid / in_ready  | start_req (one beat per microsecond tick)
//   out_    | out       | out_valid / out_ready| send_count, remaining, current_delay,
//           |           |                      | adjusted, busy_res (one beat per tick)
//   cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data (always ready)
//
// A plain tick runs the idle, evaluate and output states; a run start adds a residue divide of
// the packet total by WINDOW; a window boundary adds a lateness divide and calibration, plus a
// residue divide when a catch-up burst is sent, all on the shared 32-step serial divider.
// Reset is synchronous and active low; config returns to its reset values, the run stops.
// One tick is in flight at a time; a result beat waits in the output register while the next
// input beat is taken, and a tick stalls in its last cycle only while that register is full.
`default_nettype none

module self_calibrating_packet_pacer_unit
  import spp_pkg::*;
#(
  parameter int WINDOW    = WINDOW_DEF,
  parameter int MAX_BURST = MAX_BURST_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_start_req,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SEND_W-1:0]     out_send_count,
  output logic [COUNT_W-1:0]    out_remaining,
  output logic [DELAY_W-1:0]    out_current_delay,
  output logic [ADJ_W-1:0]      out_adjusted,
  output logic                  out_busy_res,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  spp_cmd_t cmd;
  spp_sts_t sts;

  assign cfg_ready = 1'b1;

  spp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  spp_dp #(
    .WINDOW    (WINDOW),
    .MAX_BURST (MAX_BURST)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_start_req      (in_start_req),
    .cfg_we            (cfg_valid & cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_ready         (out_ready),
    .out_valid         (out_valid),
    .out_send_count    (out_send_count),
    .out_remaining     (out_remaining),
    .out_current_delay (out_current_delay),
    .out_adjusted      (out_adjusted),
    .out_busy_res      (out_busy_res)
  );

endmodule

`default_nettype wire

[design/spp_chk.sv]
// Port-level checker for the packet pacer, bound to the top level.
`default_nettype none

module spp_chk
  import spp_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  in_start_req,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [SEND_W-1:0]     out_send_count,
  input logic [COUNT_W-1:0]    out_remaining,
  input logic [DELAY_W-1:0]    out_current_delay,
  input logic [ADJ_W-1:0]      out_adjusted,
  input logic                  out_busy_res,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_send_count)
      && $stable(out_remaining) && $stable(out_current_delay)
      && $stable(out_adjusted) && $stable(out_busy_res))
    else $error("result beat changed while stalled");

  // Only one tick is worked on at a time
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a tick is in progress");

  // An idle pacer has nothing left to send
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_busy_res |-> out_remaining == '0)
    else $error("packets left while idle");

  // Calibration only happens on a tick that launches packets
  a_adj_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_adjusted != ADJ_NONE |-> out_send_count != '0)
    else $error("delay adjusted on a tick without sends");

endmodule

bind self_calibrating_packet_pacer_unit spp_chk u_spp_chk (.*);

`default_nettype wire
